>>> src/tsts_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the time-slice task scheduler
// no dependencies

package tsts_pkg;

  localparam int MAX_TASKS   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);
  localparam int DCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int ID_W        = 4;
  localparam int TICK_W      = 32;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_SCAN       = 3'd1,
    REQ_REGISTER   = 3'd2,
    REQ_DELAY      = 3'd3,
    REQ_DELAY_ALL  = 3'd4,
    REQ_TERMINATE  = 3'd5,
    REQ_REWORK     = 3'd6,
    REQ_READ_TICK  = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_READY      = 2'd0,
    ST_BLOCKED    = 2'd1,
    ST_TERMINATED = 2'd2
  } task_st_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SCAN_END,
    S_ALL
  } fsm_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_slot;
    logic all_slot;
    logic scan_end;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic ptr_last;
  } dp_stat_t;

endpackage

>>> src/tsts_ctrl.sv
`timescale 1ns / 1ps
// request sequencer of the task scheduler
// depends on tsts_pkg

module tsts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         req_type,
  input  tsts_pkg::dp_stat_t stat,
  output logic               busy,
  output tsts_pkg::ctl_cmd_t cmd
);

  tsts_pkg::fsm_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      tsts_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          if (tsts_pkg::req_e'(req_type) == tsts_pkg::REQ_SCAN && !stat.cnt_zero) begin
            state_next = tsts_pkg::S_SCAN;
          end else if (tsts_pkg::req_e'(req_type) == tsts_pkg::REQ_DELAY_ALL &&
                       !stat.cnt_zero) begin
            state_next = tsts_pkg::S_ALL;
          end else begin
            state_next = tsts_pkg::S_EXEC;
          end
        end
      end
      tsts_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = tsts_pkg::S_IDLE;
      end
      tsts_pkg::S_SCAN: begin
        cmd.scan_slot = 1'b1;
        if (stat.ptr_last) begin
          state_next = tsts_pkg::S_SCAN_END;
        end
      end
      tsts_pkg::S_SCAN_END: begin
        cmd.scan_end = 1'b1;
        state_next   = tsts_pkg::S_IDLE;
      end
      tsts_pkg::S_ALL: begin
        cmd.all_slot = 1'b1;
        if (stat.ptr_last) begin
          state_next = tsts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tsts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> src/tsts_dp.sv
`timescale 1ns / 1ps
// task table, tick counter and result registers of the task scheduler
// depends on tsts_pkg

module tsts_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tsts_pkg::ctl_cmd_t            cmd,
  input  logic [2:0]                    req_type,
  input  logic [3:0]                    task_index,
  input  logic [31:0]                   tick_step,
  input  logic [31:0]                   task_period,
  input  logic [31:0]                   delay_ticks,
  output tsts_pkg::dp_stat_t            stat,
  output logic                          result_strobe,
  output logic                          status,
  output logic [tsts_pkg::ID_W-1:0]     task_id,
  output logic                          dispatch,
  output logic [tsts_pkg::TICK_W-1:0]   tick_value,
  output logic                          last
);

  tsts_pkg::task_st_e                 task_state    [tsts_pkg::MAX_TASKS];
  logic [tsts_pkg::TICK_W-1:0]        task_deadline [tsts_pkg::MAX_TASKS];
  logic [tsts_pkg::TICK_W-1:0]        task_slice    [tsts_pkg::MAX_TASKS];

  logic [tsts_pkg::TICK_W-1:0] tick_count;
  logic [tsts_pkg::CNT_W-1:0]  used_slots;
  logic [tsts_pkg::SLOT_W-1:0] ptr;
  logic [tsts_pkg::DCNT_W-1:0] ndisp;
  logic                        pend_v;
  logic [tsts_pkg::SLOT_W-1:0] pend_id;

  tsts_pkg::req_e              req_q;
  logic [3:0]                  idx_q;
  logic [31:0]                 step_q;
  logic [31:0]                 period_q;
  logic [31:0]                 delay_q;

  logic [tsts_pkg::SLOT_W-1:0] idx_slot;
  logic [tsts_pkg::SLOT_W-1:0] cnt_slot;
  logic [tsts_pkg::SLOT_W-1:0] rd_addr;
  tsts_pkg::task_st_e          rd_state;
  logic [tsts_pkg::TICK_W-1:0] rd_deadline;
  logic [tsts_pkg::TICK_W-1:0] rd_slice;
  logic [tsts_pkg::TICK_W-1:0] late;
  logic                        due;
  logic                        slot_ok;
  logic                        full;
  logic                        room;

  assign idx_slot    = (tsts_pkg::SLOT_W)'(idx_q);
  assign cnt_slot    = (tsts_pkg::SLOT_W)'(used_slots);
  assign rd_addr     = (cmd.scan_slot || cmd.all_slot) ? ptr : idx_slot;
  assign rd_state    = task_state[rd_addr];
  assign rd_deadline = task_deadline[rd_addr];
  assign rd_slice    = task_slice[rd_addr];
  assign late        = tick_count - rd_deadline;
  assign due         = !late[tsts_pkg::TICK_W-1];
  assign slot_ok     = 32'(idx_q) < 32'(used_slots);
  assign full        = used_slots == (tsts_pkg::CNT_W)'(tsts_pkg::MAX_TASKS);
  assign room        = ndisp < (tsts_pkg::DCNT_W)'(tsts_pkg::MAX_RESULTS);

  assign stat.cnt_zero = used_slots == '0;
  assign stat.ptr_last = (tsts_pkg::CNT_W)'(ptr) + (tsts_pkg::CNT_W)'(1) == used_slots;
  assign tick_value    = tick_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      used_slots    <= '0;
      result_strobe <= 1'b0;
      pend_v        <= 1'b0;
      ptr           <= '0;
      ndisp         <= '0;
    end else begin
      result_strobe <= 1'b0;

      if (cmd.latch) begin
        req_q    <= tsts_pkg::req_e'(req_type);
        idx_q    <= task_index;
        step_q   <= tick_step;
        period_q <= task_period;
        delay_q  <= delay_ticks;
        ptr      <= '0;
        pend_v   <= 1'b0;
        ndisp    <= '0;
      end

      if (cmd.exec) begin
        result_strobe <= 1'b1;
        status        <= 1'b0;
        task_id       <= '0;
        dispatch      <= 1'b0;
        last          <= 1'b1;
        unique case (req_q)
          tsts_pkg::REQ_TICK: begin
            tick_count <= tick_count + step_q;
          end
          tsts_pkg::REQ_REGISTER: begin
            if (period_q == '0 || full) begin
              status <= 1'b1;
            end else begin
              task_state[cnt_slot]    <= tsts_pkg::ST_READY;
              task_slice[cnt_slot]    <= period_q;
              task_deadline[cnt_slot] <= period_q;
              used_slots              <= used_slots + (tsts_pkg::CNT_W)'(1);
              task_id                 <= (tsts_pkg::ID_W)'(cnt_slot);
            end
          end
          tsts_pkg::REQ_DELAY: begin
            if (!slot_ok || rd_state == tsts_pkg::ST_TERMINATED) begin
              status <= 1'b1;
            end else begin
              task_state[idx_slot]    <= tsts_pkg::ST_BLOCKED;
              task_deadline[idx_slot] <= tick_count + delay_q;
            end
          end
          tsts_pkg::REQ_TERMINATE: begin
            if (!slot_ok) begin
              status <= 1'b1;
            end else begin
              task_state[idx_slot]    <= tsts_pkg::ST_TERMINATED;
              task_deadline[idx_slot] <= '0;
            end
          end
          tsts_pkg::REQ_REWORK: begin
            if (!slot_ok) begin
              status <= 1'b1;
            end else begin
              task_state[idx_slot]    <= tsts_pkg::ST_READY;
              task_deadline[idx_slot] <= tick_count + rd_slice;
            end
          end
          default: begin
          end
        endcase
      end

      if (cmd.scan_slot) begin
        ptr <= ptr + (tsts_pkg::SLOT_W)'(1);
        if (rd_state == tsts_pkg::ST_READY) begin
          if (room && due) begin
            task_deadline[ptr] <= tick_count + rd_slice;
            ndisp              <= ndisp + (tsts_pkg::DCNT_W)'(1);
            pend_v             <= 1'b1;
            pend_id            <= ptr;
            if (pend_v) begin
              result_strobe <= 1'b1;
              status        <= 1'b0;
              task_id       <= (tsts_pkg::ID_W)'(pend_id);
              dispatch      <= 1'b1;
              last          <= 1'b0;
            end
          end
        end else if (rd_state == tsts_pkg::ST_BLOCKED) begin
          if (due) begin
            task_deadline[ptr] <= tick_count + rd_slice;
            task_state[ptr]    <= tsts_pkg::ST_READY;
          end
        end
      end

      if (cmd.scan_end) begin
        result_strobe <= 1'b1;
        status        <= 1'b0;
        task_id       <= pend_v ? (tsts_pkg::ID_W)'(pend_id) : '0;
        dispatch      <= pend_v;
        last          <= 1'b1;
      end

      if (cmd.all_slot) begin
        ptr <= ptr + (tsts_pkg::SLOT_W)'(1);
        if (rd_state != tsts_pkg::ST_TERMINATED) begin
          task_state[ptr]    <= tsts_pkg::ST_BLOCKED;
          task_deadline[ptr] <= tick_count + delay_q;
        end
        if (stat.ptr_last) begin
          result_strobe <= 1'b1;
          status        <= 1'b0;
          task_id       <= '0;
          dispatch      <= 1'b0;
          last          <= 1'b1;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used_slots) <= 32'(tsts_pkg::MAX_TASKS))
    else $error("task count beyond table size");

  a_disp_ok: assert property (@(posedge clk) disable iff (rst)
    result_strobe && dispatch |-> !status)
    else $error("dispatch beat flagged as error");

  a_not_last_disp: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> dispatch)
    else $error("non-final beat without dispatch");

  a_scan_end_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_end |=> result_strobe && last)
    else $error("scan ended without final beat");

  a_disp_cap: assert property (@(posedge clk) disable iff (rst)
    32'(ndisp) <= 32'(tsts_pkg::MAX_RESULTS))
    else $error("dispatch count beyond limit");

endmodule

>>> src/time_slice_task_scheduler.sv
`timescale 1ns / 1ps
// top level of the time-slice task scheduler
// single requests: the request is latched, executed in the EXEC state and its result beat registered
// scan: walks every registered slot, then gives a final beat; a dispatch beat waits for the next dispatch
// delay all: walks every registered slot; busy stays high while the slot walk runs
// a new request is taken only while busy is low, once the previous one has finished
// reset clears tick counter and task count; results cannot be stalled by the receiver

module time_slice_task_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type,
  input  logic [3:0]                  task_index,
  input  logic [31:0]                 tick_step,
  input  logic [31:0]                 task_period,
  input  logic [31:0]                 delay_ticks,
  output logic                        result_strobe,
  output logic                        status,
  output logic [tsts_pkg::ID_W-1:0]   task_id,
  output logic                        dispatch,
  output logic [tsts_pkg::TICK_W-1:0] tick_value,
  output logic                        last
);

  tsts_pkg::ctl_cmd_t cmd;
  tsts_pkg::dp_stat_t stat;

  tsts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  tsts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .task_index    (task_index),
    .tick_step     (tick_step),
    .task_period   (task_period),
    .delay_ticks   (delay_ticks),
    .stat          (stat),
    .result_strobe (result_strobe),
    .status        (status),
    .task_id       (task_id),
    .dispatch      (dispatch),
    .tick_value    (tick_value),
    .last          (last)
  );

endmodule
